@@ sv/lgs_pkg.sv @@
`default_nettype none
package lgs_pkg;

  localparam int GRID_COLS = 30;
  localparam int GRID_ROWS = 15;
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);

  typedef enum logic [2:0] {
    OP_STEP    = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_SET     = 3'd2,
    OP_BLOCK   = 3'd3,
    OP_BEEHIVE = 3'd4
  } lgs_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PRIME,
    ST_STEP,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_DRAW_OUT
  } lgs_state_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]     column_index;
    logic [GRID_ROWS-1:0] column_bits;
    logic                 last;
  } out_word_t;

  // three rows of one pattern column, bit 0 is the origin row
  typedef struct packed {
    logic [2:0] mask;
    logic [2:0] val;
  } draw_pat_t;

  // start pattern: (3,3) (5,3) (4,4) (4,5) (5,4)
  function automatic logic [GRID_ROWS-1:0] init_column(input logic [COL_W-1:0] c);
    logic [GRID_ROWS-1:0] bits;
    bits = '0;
    case (c)
      COL_W'(3): bits = GRID_ROWS'(15'h0008);
      COL_W'(4): bits = GRID_ROWS'(15'h0030);
      COL_W'(5): bits = GRID_ROWS'(15'h0018);
      default:   bits = '0;
    endcase
    return bits;
  endfunction

  function automatic draw_pat_t draw_pattern(input logic [2:0] op, input logic [2:0] off,
                                             input logic hive_ok);
    draw_pat_t p;
    p = '0;
    case (op)
      OP_CLEAR: begin
        p.mask = (off == 3'd0) ? 3'b001 : 3'b000;
        p.val  = 3'b000;
      end
      OP_SET: begin
        p.mask = (off == 3'd0) ? 3'b001 : 3'b000;
        p.val  = 3'b001;
      end
      OP_BLOCK: begin
        p.mask = 3'b111;
        p.val  = (off == 3'd0) ? 3'b000 : 3'b110;
      end
      OP_BEEHIVE: begin
        if (hive_ok) begin
          p.mask = 3'b111;
          p.val  = (off == 3'd0 || off == 3'd3) ? 3'b010 : 3'b101;
        end
      end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ sv/lgs_ram.sv @@
`default_nettype none
module lgs_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 30
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/lgs_life_col.sv @@
`default_nettype none
module lgs_life_col (
  input  wire [lgs_pkg::GRID_ROWS-1:0] prev_col,
  input  wire [lgs_pkg::GRID_ROWS-1:0] cur_col,
  input  wire [lgs_pkg::GRID_ROWS-1:0] next_col,
  output logic [lgs_pkg::GRID_ROWS-1:0] new_col
);
  import lgs_pkg::*;

  logic [GRID_ROWS+1:0] p_pad;
  logic [GRID_ROWS+1:0] c_pad;
  logic [GRID_ROWS+1:0] n_pad;
  logic [3:0]           cnt;

  // rows outside the grid read as dead
  assign p_pad = {1'b0, prev_col, 1'b0};
  assign c_pad = {1'b0, cur_col, 1'b0};
  assign n_pad = {1'b0, next_col, 1'b0};

  always_comb begin
    cnt = '0;
    new_col = '0;
    for (int r = 0; r < GRID_ROWS; r++) begin
      cnt = 4'(p_pad[r]) + 4'(p_pad[r+1]) + 4'(p_pad[r+2])
          + 4'(c_pad[r]) + 4'(c_pad[r+2])
          + 4'(n_pad[r]) + 4'(n_pad[r+1]) + 4'(n_pad[r+2]);
      new_col[r] = (cnt == 4'd3) || (cnt == 4'd2 && c_pad[r+1]);
    end
  end

endmodule
`default_nettype wire

@@ sv/life_grid_generation_step.sv @@
// life grid, rule B3/S23, 30 columns by 15 rows, edges do not wrap.
// input channel (in_valid/in_ready/in_data): one word per command. op step
// computes the next generation and answers with 30 words, columns 0 to 29,
// last set on column 29. draw ops (clear, set, block, beehive) answer with
// one word holding column pos_x after the write, last set; unknown ops
// give no answer.
// a step accepts the command, primes the read of column 0, then moves one
// column per cycle through the grid memory while the receiver takes words
// (read of column c+2 while column c is written back). a draw reads and
// writes back each touched column, up to 4 columns, then finds the end of
// the pattern and outputs one word; pos_x outside the grid touches none.
// results leave through an output register, so the next command is taken as
// soon as the engine is idle even while the last word waits. a stalled
// receiver holds the sweep in place; nothing is dropped.
// after reset the memory is loaded with the five-cell start pattern, one
// column a cycle, with in_ready low.
`default_nettype none
module life_grid_generation_step (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire lgs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output lgs_pkg::out_word_t  out_data
);
  import lgs_pkg::*;

  lgs_state_t           state_r, state_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [2:0]           off_r, off_nxt;
  logic [2:0]           op_r, op_nxt;
  logic [COL_W-1:0]     x_r, x_nxt;
  logic [ROW_W-1:0]     y_r, y_nxt;
  logic [GRID_ROWS-1:0] prev_r, prev_nxt;
  logic [GRID_ROWS-1:0] cur_r, cur_nxt;
  logic [GRID_ROWS-1:0] hold_r, hold_nxt;
  logic                 out_valid_r;
  out_word_t            out_data_r, out_data_nxt;
  logic                 out_load;

  logic                 ram_we;
  logic [COL_W-1:0]     ram_waddr;
  logic [GRID_ROWS-1:0] ram_wdata;
  logic                 ram_re;
  logic [COL_W-1:0]     ram_raddr;
  logic [GRID_ROWS-1:0] ram_rdata;

  logic [GRID_ROWS-1:0] window_next;
  logic [GRID_ROWS-1:0] life_col;
  logic                 slot_free;
  logic                 last_col;
  logic [COL_W:0]       ahead_addr;
  logic [COL_W:0]       draw_addr;
  logic                 hive_ok;
  logic [2:0]           draw_cols;
  draw_pat_t            pat;
  logic [GRID_ROWS+2:0] mask_wide;
  logic [GRID_ROWS+2:0] val_wide;
  logic [GRID_ROWS-1:0] draw_mask;
  logic [GRID_ROWS-1:0] draw_val;

  lgs_ram #(
    .WIDTH (GRID_ROWS),
    .DEPTH (GRID_COLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lgs_life_col u_life (
    .prev_col (prev_r),
    .cur_col  (cur_r),
    .next_col (window_next),
    .new_col  (life_col)
  );

  assign slot_free   = !out_valid_r || out_ready;
  assign last_col    = (col_r == COL_W'(GRID_COLS - 1));
  assign window_next = last_col ? '0 : ram_rdata;
  assign ahead_addr  = {1'b0, col_r} + (COL_W+1)'(2);

  // draw geometry
  assign draw_addr = {1'b0, x_r} + (COL_W+1)'(off_r);
  assign hive_ok   = ({1'b0, x_r} + (COL_W+1)'(3)) < (COL_W+1)'(GRID_COLS);
  assign pat       = draw_pattern(op_r, off_r, hive_ok);
  assign mask_wide = {{GRID_ROWS{1'b0}}, pat.mask} << y_r;
  assign val_wide  = {{GRID_ROWS{1'b0}}, pat.val} << y_r;
  assign draw_mask = mask_wide[GRID_ROWS-1:0];
  assign draw_val  = val_wide[GRID_ROWS-1:0];

  always_comb begin
    case (op_r)
      OP_CLEAR, OP_SET: draw_cols = 3'd1;
      OP_BLOCK:         draw_cols = 3'd3;
      // an ignored beehive still reads column x once for the answer
      OP_BEEHIVE:       draw_cols = hive_ok ? 3'd4 : 3'd1;
      default:          draw_cols = 3'd0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    off_nxt      = off_r;
    op_nxt       = op_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    hold_nxt     = hold_r;
    out_data_nxt = out_data_r;
    out_load     = 1'b0;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = col_r;
    ram_wdata    = life_col;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = col_r;
        ram_wdata = init_column(col_r);
        if (last_col) begin
          col_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_data.op;
          x_nxt   = in_data.pos_x;
          y_nxt   = in_data.pos_y;
          off_nxt = '0;
          case (in_data.op)
            OP_STEP: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = ST_PRIME;
            end
            OP_CLEAR, OP_SET, OP_BLOCK, OP_BEEHIVE: begin
              state_nxt = ST_DRAW_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_PRIME: begin
        prev_nxt  = '0;
        cur_nxt   = ram_rdata;
        col_nxt   = '0;
        ram_re    = 1'b1;
        ram_raddr = COL_W'(1);
        state_nxt = ST_STEP;
      end

      ST_STEP: begin
        // window is prev_r, cur_r and the column just read
        if (slot_free) begin
          ram_we       = 1'b1;
          ram_waddr    = col_r;
          ram_wdata    = life_col;
          out_load     = 1'b1;
          out_data_nxt = '{column_index: col_r, column_bits: life_col, last: last_col};
          prev_nxt     = cur_r;
          cur_nxt      = window_next;
          if (last_col) begin
            col_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = col_r + COL_W'(1);
            ram_raddr = ahead_addr[COL_W-1:0];
            ram_re    = (ahead_addr < (COL_W+1)'(GRID_COLS));
          end
        end
      end

      ST_DRAW_RD: begin
        if (off_r < draw_cols && draw_addr < (COL_W+1)'(GRID_COLS)) begin
          ram_re    = 1'b1;
          ram_raddr = draw_addr[COL_W-1:0];
          state_nxt = ST_DRAW_WR;
        end else begin
          state_nxt = ST_DRAW_OUT;
        end
      end

      ST_DRAW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = draw_addr[COL_W-1:0];
        ram_wdata = (ram_rdata & ~draw_mask) | (draw_val & draw_mask);
        if (off_r == 3'd0) begin
          hold_nxt = ram_wdata;
        end
        off_nxt   = off_r + 3'd1;
        state_nxt = ST_DRAW_RD;
      end

      ST_DRAW_OUT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{column_index: x_r,
                           column_bits: ({1'b0, x_r} < (COL_W+1)'(GRID_COLS)) ? hold_r : '0,
                           last: 1'b1};
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      off_r   <= off_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import lgs_pkg::*;

  // op codes the block has no use for, it answers them with nothing
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  // beehive rows from the origin downward, bit i is column pos_x + i
  localparam logic [11:0] HIVE_ROWS = 12'h696;

  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_WORDS  = 300;
  localparam int QUIET_FROM    = 260;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [2:0]           op;
    logic [COL_W-1:0]     pos_x;
    logic [ROW_W-1:0]     pos_y;
    logic                 pinned;
    logic [GRID_ROWS-1:0] bits;
  } stim_row_t;

  // pinned rows carry the column that can be read straight off the start pattern
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_CLEAR,    5'd4,  4'd0,  1'b1, 15'h0030},
    '{OP_SET,      5'd5,  4'd3,  1'b1, 15'h0018},
    '{OP_SET,      5'd3,  4'd14, 1'b1, 15'h4008},
    '{OP_CLEAR,    5'd3,  4'd14, 1'b1, 15'h0008},
    '{OP_STEP,     5'd0,  4'd0,  1'b0, 15'h0000},
    '{OP_STEP,     5'd31, 4'd15, 1'b0, 15'h0000},
    '{OP_SET,      5'd0,  4'd0,  1'b0, 15'h0000},
    '{OP_SET,      5'd29, 4'd14, 1'b0, 15'h0000},
    '{OP_SET,      5'd31, 4'd15, 1'b1, 15'h0000},
    '{OP_CLEAR,    5'd30, 4'd0,  1'b1, 15'h0000},
    '{OP_SET,      5'd0,  4'd15, 1'b0, 15'h0000},
    '{OP_BLOCK,    5'd0,  4'd0,  1'b0, 15'h0000},
    '{OP_BLOCK,    5'd28, 4'd13, 1'b0, 15'h0000},
    '{OP_BLOCK,    5'd31, 4'd7,  1'b1, 15'h0000},
    '{OP_BEEHIVE,  5'd26, 4'd5,  1'b0, 15'h0000},
    '{OP_BEEHIVE,  5'd27, 4'd5,  1'b0, 15'h0000},
    '{OP_BEEHIVE,  5'd10, 4'd13, 1'b0, 15'h0000},
    '{OP_BEEHIVE,  5'd30, 4'd0,  1'b1, 15'h0000},
    '{OP_SPARE_LO, 5'd1,  4'd1,  1'b0, 15'h0000},
    '{OP_SPARE_MID, 5'd31, 4'd15, 1'b0, 15'h0000},
    '{OP_SPARE_HI, 5'd0,  4'd0,  1'b0, 15'h0000},
    '{OP_STEP,     5'd0,  4'd0,  1'b0, 15'h0000},
    '{OP_BLOCK,    5'd12, 4'd6,  1'b0, 15'h0000},
    '{OP_STEP,     5'd0,  4'd0,  1'b0, 15'h0000}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic [GRID_ROWS-1:0] life_cols [GRID_COLS];
  logic [GRID_ROWS-1:0] prior_cols [GRID_COLS];
  out_word_t            pending_columns [$];
  int                   mismatch_count = 0;
  bit                   quiet_tail = 1'b0;

  life_grid_generation_step dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void life_put_cell(input int x, input int y, input bit alive);
    if (x < 0 || x >= GRID_COLS || y < 0 || y >= GRID_ROWS) return;
    life_cols[x][y] = alive;
  endfunction

  function automatic bit life_prior_cell(input int x, input int y);
    if (x < 0 || x >= GRID_COLS || y < 0 || y >= GRID_ROWS) return 1'b0;
    return prior_cols[x][y];
  endfunction

  function automatic void life_reset_grid();
    for (int c = 0; c < GRID_COLS; c++) life_cols[c] = '0;
    life_put_cell(3, 3, 1'b1);
    life_put_cell(5, 3, 1'b1);
    life_put_cell(4, 4, 1'b1);
    life_put_cell(4, 5, 1'b1);
    life_put_cell(5, 4, 1'b1);
  endfunction

  // B3/S23 on a snapshot, so every column sees the old generation
  function automatic void life_advance();
    int n;
    logic [GRID_ROWS-1:0] word;
    for (int c = 0; c < GRID_COLS; c++) prior_cols[c] = life_cols[c];
    for (int c = 0; c < GRID_COLS; c++) begin
      word = '0;
      for (int r = 0; r < GRID_ROWS; r++) begin
        n = 0;
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++)
            if (dx != 0 || dy != 0) n += life_prior_cell(c + dx, r + dy);
        if (n == 3 || (n == 2 && life_prior_cell(c, r))) word[r] = 1'b1;
      end
      life_cols[c] = word;
    end
  endfunction

  function automatic void life_apply_word(input in_word_t w, input bit pinned,
                                          input logic [GRID_ROWS-1:0] pinned_bits);
    int x;
    int y;
    out_word_t e;
    x = w.pos_x;
    y = w.pos_y;
    if (w.op == OP_STEP) begin
      life_advance();
      for (int c = 0; c < GRID_COLS; c++) begin
        e.column_index = COL_W'(c);
        e.column_bits  = life_cols[c];
        e.last         = (c == GRID_COLS - 1);
        pending_columns.push_back(e);
      end
      return;
    end
    if (w.op > OP_BEEHIVE) return;
    case (w.op)
      OP_CLEAR: life_put_cell(x, y, 1'b0);
      OP_SET:   life_put_cell(x, y, 1'b1);
      OP_BLOCK: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            life_put_cell(x + i, y + j, i != 0 && j != 0);
      end
      default: begin
        // whole beehive dropped when it would cross the right edge
        if (x + 3 < GRID_COLS)
          for (int j = 0; j < 3; j++)
            for (int i = 0; i < 4; i++)
              life_put_cell(x + i, y + j, HIVE_ROWS[j * 4 + i]);
      end
    endcase
    e.column_index = w.pos_x;
    e.column_bits  = (x < GRID_COLS) ? life_cols[x] : '0;
    if (pinned) e.column_bits = pinned_bits;
    e.last = 1'b1;
    pending_columns.push_back(e);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send_word(input in_word_t w, input bit pinned,
                           input logic [GRID_ROWS-1:0] pinned_bits);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    life_apply_word(w, pinned, pinned_bits);
  endtask

  // receiver: stall bursts, then stretches of steady ready
  initial begin
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_word
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("word with nothing pending, column", out_data.column_index, 0);
      end else begin
        want = pending_columns.pop_front();
        if (out_data.column_index !== want.column_index)
          report_mismatch("column_index", out_data.column_index, want.column_index);
        if (out_data.column_bits !== want.column_bits)
          report_mismatch("column_bits", out_data.column_bits, want.column_bits);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  initial begin : stimulus
    in_word_t w;
    int placed;
    int pick;
    life_reset_grid();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      w.op    = directed_rows[k].op;
      w.pos_x = directed_rows[k].pos_x;
      w.pos_y = directed_rows[k].pos_y;
      send_word(w, directed_rows[k].pinned, directed_rows[k].bits);
    end

    placed = 0;
    while (placed < RANDOM_WORDS) begin
      pick    = $urandom_range(0, 99);
      w.pos_x = COL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(30, 31)
                                                   : $urandom_range(0, 29));
      w.pos_y = ROW_W'($urandom_range(0, 15));
      if (pick < 18)
        w.op = OP_STEP;
      else if (pick < 22)
        w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if (pick < 30)
        w.op = pick[0] ? OP_BLOCK : OP_BEEHIVE;
      else
        w.op = (pick < 75) ? OP_SET : OP_CLEAR;
      if (placed >= QUIET_FROM) quiet_tail = 1'b1;
      send_word(w, 1'b0, '0);
      if (w.op <= OP_BEEHIVE) placed++;
    end
    in_valid <= 1'b0;

    while (pending_columns.size() != 0) @(posedge clk);
    // room for a stray word after the last expected one
    repeat (64) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
